// File: rtl/core/bfic_pkg.sv
`timescale 1ns / 1ps

package bfic_pkg;

   localparam int MaxBits     = 65536;
   localparam int MaxHashes   = 16;
   localparam int MaxKeyBytes = 4096;
   localparam int StoreWords  = MaxBits / 64;
   localparam int AddrW       = $clog2(StoreWords);
   localparam int HashIdxW    = $clog2(MaxHashes);
   localparam int LenW        = $clog2(MaxKeyBytes) + 1;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_CHECK  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] CSR_NUM_BITS   = 2'd0;
   localparam logic [1:0] CSR_NUM_HASHES = 2'd1;
   localparam logic [1:0] CSR_SEED       = 2'd2;

   localparam logic [31:0] C1      = 32'hcc9e2d51;
   localparam logic [31:0] C2      = 32'h1b873593;
   localparam logic [31:0] MIX_ADD = 32'he6546b64;
   localparam logic [31:0] FMIX1   = 32'h85ebca6b;
   localparam logic [31:0] FMIX2   = 32'hc2b2ae35;

   localparam logic [31:0] SEED_TABLE [MaxHashes] = '{
      32'h0edb8832, 32'h79dcb8a4, 32'he0d5e91e, 32'h97d2d988,
      32'h09b64c2b, 32'h7eb17cbd, 32'he7b82d07, 32'h90bf1d91,
      32'h1db71064, 32'h6ab020f2, 32'hf3b97148, 32'h84be41de,
      32'h1adad47d, 32'h6ddde4eb, 32'hf4d4b551, 32'h83d385c7
   };

   typedef enum logic [12:0] {
      ST_CLR  = 13'b0000000000001,
      ST_IDLE = 13'b0000000000010,
      ST_MUL1 = 13'b0000000000100,
      ST_MUL2 = 13'b0000000001000,
      ST_MIX  = 13'b0000000010000,
      ST_END  = 13'b0000000100000,
      ST_FIN0 = 13'b0000001000000,
      ST_FM1  = 13'b0000010000000,
      ST_FM2  = 13'b0000100000000,
      ST_DIV  = 13'b0001000000000,
      ST_RD   = 13'b0010000000000,
      ST_CHK  = 13'b0100000000000,
      ST_RESP = 13'b1000000000000
   } state_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      rotl32 = (x << r) | (x >> (32 - r));
   endfunction

endpackage

// File: rtl/core/bloom_filter_insert_check.sv
`timescale 1ns / 1ps

// Bloom filter insert and check with seeded MurmurHash3 x86_32 hashing. A key arrives as
// beats of 32-bit little-endian words; every beat with mode 3 is dropped, and a result beat
// follows each last word and each clear. One shared multiplier and one one-bit-per-cycle
// remainder unit do all the work, and the block takes no beat while busy. A full key word
// passes two scramble multiplies, then 16 hash states mixed one per cycle. The last word
// adds, per active hash, three finalizer steps, 32 remainder steps and a read-modify-write
// of the bit store. A clear sweeps the 1024-word store, and the same clearing pass runs
// after reset before the first beat is taken.
module bloom_filter_insert_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_key_word,
   input  logic [2:0]  req_word_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_present,
   output logic [16:0] rsp_set_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   bfic_pkg::state_type state_ff, state_in;

   logic [16:0] num_bits_ff;
   logic [4:0]  num_hashes_ff;
   logic [31:0] seed_ff;

   logic [63:0] store_mem [bfic_pkg::StoreWords];
   logic [63:0] rd_data_ff;
   logic [bfic_pkg::AddrW-1:0] clr_idx_ff;
   logic        clr_resp_ff;

   logic [31:0] rh_ff [bfic_pkg::MaxHashes];
   logic [bfic_pkg::LenW-1:0] len_ff;
   logic        too_long_ff;
   logic        fresh_ff;
   logic [16:0] count_ff;

   logic [1:0]  mode_ff;
   logic [31:0] word_ff;
   logic        last_ff;
   logic        full_ff;
   logic [31:0] k_ff;
   logic [bfic_pkg::HashIdxW-1:0] hi_ff;
   logic [31:0] f_ff;
   logic [17:0] rem_ff;
   logic [4:0]  div_cnt_ff;
   logic        present_ff;

   logic        rsp_valid_ff, rsp_accepted_ff, rsp_present_ff;
   logic [16:0] rsp_count_ff;

   logic        accept;
   logic [2:0]  n_bytes;
   logic [bfic_pkg::LenW:0] len_sum;
   logic [31:0] base, mixed, word_masked, fin_x, mul_a, mul_b, mul_p;
   logic [16:0] nb;
   logic [4:0]  nh;
   logic [17:0] rem_shift;
   logic        bit_hit;
   logic        key_ok;

   assign req_ready = (state_ff == bfic_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_present   = rsp_present_ff;
   assign rsp_set_count = rsp_count_ff;

   always_comb begin
      if (!req_last || req_word_bytes > 3'd4) begin
         n_bytes = 3'd4;
      end else begin
         n_bytes = req_word_bytes;
      end
      len_sum = {1'b0, len_ff} + (bfic_pkg::LenW + 1)'(n_bytes);

      case (req_word_bytes[1:0])
         2'd1:    word_masked = {24'h0, req_key_word[7:0]};
         2'd2:    word_masked = {16'h0, req_key_word[15:0]};
         2'd3:    word_masked = {8'h0, req_key_word[23:0]};
         default: word_masked = req_key_word;
      endcase

      if (num_bits_ff < 17'd64) begin
         nb = 17'd64;
      end else if (num_bits_ff > 17'(bfic_pkg::MaxBits)) begin
         nb = 17'(bfic_pkg::MaxBits);
      end else begin
         nb = num_bits_ff;
      end
      nh = (num_hashes_ff > 5'(bfic_pkg::MaxHashes)) ? 5'(bfic_pkg::MaxHashes)
                                                     : num_hashes_ff;

      base  = fresh_ff ? (seed_ff + bfic_pkg::SEED_TABLE[hi_ff]) : rh_ff[hi_ff];
      mixed = bfic_pkg::rotl32(base ^ k_ff, 13);
      fin_x = rh_ff[hi_ff] ^ {{(32 - bfic_pkg::LenW){1'b0}}, len_ff};

      // The one multiplier is shared by the scramble and the finalizer steps.
      case (state_ff)
         bfic_pkg::ST_MUL1: begin
            mul_a = word_ff;
            mul_b = bfic_pkg::C1;
         end
         bfic_pkg::ST_MUL2: begin
            mul_a = bfic_pkg::rotl32(k_ff, 15);
            mul_b = bfic_pkg::C2;
         end
         bfic_pkg::ST_FM1: begin
            mul_a = f_ff;
            mul_b = bfic_pkg::FMIX1;
         end
         default: begin
            mul_a = f_ff;
            mul_b = bfic_pkg::FMIX2;
         end
      endcase
      mul_p = mul_a * mul_b;

      rem_shift = {rem_ff[16:0], f_ff[div_cnt_ff]};
      bit_hit   = rd_data_ff[rem_ff[5:0]];
      key_ok    = !too_long_ff && (len_ff != '0);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfic_pkg::ST_CLR: begin
            if (clr_idx_ff == '1) begin
               state_in = clr_resp_ff ? bfic_pkg::ST_RESP : bfic_pkg::ST_IDLE;
            end
         end
         bfic_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == bfic_pkg::MODE_CLEAR) begin
                  state_in = bfic_pkg::ST_CLR;
               end else if (req_mode == bfic_pkg::MODE_UNUSED) begin
                  state_in = bfic_pkg::ST_IDLE;
               end else if (!too_long_ff && len_sum <= (bfic_pkg::LenW + 1)'(
                            bfic_pkg::MaxKeyBytes) && n_bytes != 3'd0) begin
                  state_in = bfic_pkg::ST_MUL1;
               end else begin
                  state_in = bfic_pkg::ST_END;
               end
            end
         end
         bfic_pkg::ST_MUL1: state_in = bfic_pkg::ST_MUL2;
         bfic_pkg::ST_MUL2: state_in = bfic_pkg::ST_MIX;
         bfic_pkg::ST_MIX: begin
            if (hi_ff == '1) begin
               state_in = bfic_pkg::ST_END;
            end
         end
         bfic_pkg::ST_END: begin
            if (!last_ff) begin
               state_in = bfic_pkg::ST_IDLE;
            end else if (key_ok && nh != 5'd0) begin
               state_in = bfic_pkg::ST_FIN0;
            end else begin
               state_in = bfic_pkg::ST_RESP;
            end
         end
         bfic_pkg::ST_FIN0: state_in = bfic_pkg::ST_FM1;
         bfic_pkg::ST_FM1:  state_in = bfic_pkg::ST_FM2;
         bfic_pkg::ST_FM2:  state_in = bfic_pkg::ST_DIV;
         bfic_pkg::ST_DIV: begin
            if (div_cnt_ff == 5'd0) begin
               state_in = bfic_pkg::ST_RD;
            end
         end
         bfic_pkg::ST_RD:  state_in = bfic_pkg::ST_CHK;
         bfic_pkg::ST_CHK: begin
            if (5'(hi_ff) + 5'd1 == nh) begin
               state_in = bfic_pkg::ST_RESP;
            end else begin
               state_in = bfic_pkg::ST_FIN0;
            end
         end
         bfic_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = bfic_pkg::ST_IDLE;
            end
         end
         default: state_in = bfic_pkg::ST_IDLE;
      endcase
   end

   // Bit store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (state_ff == bfic_pkg::ST_CLR) begin
         store_mem[clr_idx_ff] <= '0;
      end else if (state_ff == bfic_pkg::ST_CHK && mode_ff == bfic_pkg::MODE_INSERT
                   && !bit_hit) begin
         store_mem[rem_ff[bfic_pkg::AddrW+5:6]] <= rd_data_ff | (64'd1 << rem_ff[5:0]);
      end
      if (state_ff == bfic_pkg::ST_RD) begin
         rd_data_ff <= store_mem[rem_ff[bfic_pkg::AddrW+5:6]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfic_pkg::ST_CLR;
         clr_idx_ff    <= '0;
         clr_resp_ff   <= 1'b0;
         num_bits_ff   <= 17'(bfic_pkg::MaxBits);
         num_hashes_ff <= 5'd7;
         seed_ff       <= '0;
         len_ff        <= '0;
         too_long_ff   <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid) begin
            case (csr_index)
               bfic_pkg::CSR_NUM_BITS:   num_bits_ff   <= csr_data[16:0];
               bfic_pkg::CSR_NUM_HASHES: num_hashes_ff <= csr_data[4:0];
               bfic_pkg::CSR_SEED:       seed_ff       <= csr_data;
               default: ;
            endcase
         end

         case (state_ff)
            bfic_pkg::ST_CLR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff == '1) begin
                  clr_resp_ff     <= 1'b0;
                  rsp_valid_ff    <= clr_resp_ff;
                  rsp_accepted_ff <= 1'b1;
                  rsp_present_ff  <= 1'b0;
                  rsp_count_ff    <= '0;
               end
            end
            bfic_pkg::ST_IDLE: begin
               if (accept) begin
                  mode_ff  <= req_mode;
                  last_ff  <= req_last;
                  full_ff  <= (n_bytes == 3'd4);
                  word_ff  <= (n_bytes == 3'd4) ? req_key_word : word_masked;
                  fresh_ff <= (len_ff == '0) && !too_long_ff;
                  hi_ff    <= '0;
                  if (req_mode == bfic_pkg::MODE_CLEAR) begin
                     clr_idx_ff  <= '0;
                     clr_resp_ff <= 1'b1;
                     count_ff    <= '0;
                     len_ff      <= '0;
                     too_long_ff <= 1'b0;
                  end else if (req_mode != bfic_pkg::MODE_UNUSED && !too_long_ff) begin
                     if (len_sum > (bfic_pkg::LenW + 1)'(bfic_pkg::MaxKeyBytes)) begin
                        too_long_ff <= 1'b1;
                     end else begin
                        len_ff <= len_sum[bfic_pkg::LenW-1:0];
                     end
                  end
               end
            end
            bfic_pkg::ST_MUL1: k_ff <= mul_p;
            bfic_pkg::ST_MUL2: k_ff <= mul_p;
            bfic_pkg::ST_MIX: begin
               rh_ff[hi_ff] <= full_ff ? ((mixed << 2) + mixed + bfic_pkg::MIX_ADD)
                                       : (base ^ k_ff);
               hi_ff <= hi_ff + 1'b1;
            end
            bfic_pkg::ST_END: begin
               hi_ff      <= '0;
               present_ff <= 1'b1;
               if (last_ff && !(key_ok && nh != 5'd0)) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_accepted_ff <= key_ok;
                  rsp_present_ff  <= key_ok;
                  rsp_count_ff    <= count_ff;
                  len_ff          <= '0;
                  too_long_ff     <= 1'b0;
               end
            end
            bfic_pkg::ST_FIN0: f_ff <= fin_x ^ (fin_x >> 16);
            bfic_pkg::ST_FM1:  f_ff <= mul_p ^ (mul_p >> 13);
            bfic_pkg::ST_FM2: begin
               f_ff       <= mul_p ^ (mul_p >> 16);
               rem_ff     <= '0;
               div_cnt_ff <= 5'd31;
            end
            bfic_pkg::ST_DIV: begin
               // Restoring remainder, one dividend bit per cycle from the top.
               if (rem_shift >= {1'b0, nb}) begin
                  rem_ff <= rem_shift - {1'b0, nb};
               end else begin
                  rem_ff <= rem_shift;
               end
               div_cnt_ff <= div_cnt_ff - 1'b1;
            end
            bfic_pkg::ST_CHK: begin
               logic pres_next;
               pres_next = present_ff;
               if (!bit_hit) begin
                  if (mode_ff == bfic_pkg::MODE_INSERT) begin
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     pres_next = 1'b0;
                  end
               end
               present_ff <= pres_next;
               hi_ff      <= hi_ff + 1'b1;
               if (5'(hi_ff) + 5'd1 == nh) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_accepted_ff <= 1'b1;
                  rsp_present_ff  <= pres_next;
                  rsp_count_ff    <= (!bit_hit && mode_ff == bfic_pkg::MODE_INSERT)
                                     ? count_ff + 1'b1 : count_ff;
                  len_ff          <= '0;
                  too_long_ff     <= 1'b0;
               end
            end
            bfic_pkg::ST_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// File: dv/bloom_filter_insert_check_tb.sv
`timescale 1ns / 1ps

module bloom_filter_insert_check_tb;

   localparam int CycleLimit = 5000000;
   localparam int RandItems  = 550;
   localparam int QuietItems = 60;
   localparam int DrainWait  = 700;

   typedef struct packed {
      logic        accepted;
      logic        present;
      logic [16:0] set_count;
   } lookup_type;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        last;
      int          reps;
      bit          typed;
      lookup_type  res;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = bfic_pkg::MODE_INSERT;
   logic [31:0] req_key_word = '0;
   logic [2:0]  req_word_bytes = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_accepted;
   logic        rsp_present;
   logic [16:0] rsp_set_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = bfic_pkg::CSR_NUM_BITS;
   logic [31:0] csr_data = '0;

   bloom_filter_insert_check u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Own copy of the filter state and its registers.
   bit          filt [0:bfic_pkg::MaxBits-1];
   logic [31:0] hstate [bfic_pkg::MaxHashes];
   int unsigned key_len;
   bit          too_long;
   logic [16:0] bits_set;
   logic [16:0] cfg_bits;
   logic [4:0]  cfg_hashes;
   logic [31:0] cfg_seed;

   lookup_type lookup_q [$];
   int      errors = 0;
   int      cycles = 0;
   bit      quiet = 1'b0;
   bit      long_hold = 1'b0;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] scramble(input logic [31:0] k);
      return rotl(k * bfic_pkg::C1, 15) * bfic_pkg::C2;
   endfunction

   function automatic logic [31:0] fmix(input logic [31:0] h, input logic [31:0] len);
      logic [31:0] x;
      x = h ^ len;
      x = x ^ (x >> 16);
      x = x * bfic_pkg::FMIX1;
      x = x ^ (x >> 13);
      x = x * bfic_pkg::FMIX2;
      x = x ^ (x >> 16);
      return x;
   endfunction

   task automatic filter_step(input logic [1:0] mode, input logic [31:0] word,
                              input logic [2:0] nbytes, input logic last,
                              output bit has, output lookup_type r);
      int unsigned n;
      int unsigned nb;
      int unsigned nh;
      logic [31:0] k;
      logic [15:0] pos;
      has = 1'b0;
      r = '0;
      if (mode == bfic_pkg::MODE_UNUSED) return;
      if (mode == bfic_pkg::MODE_CLEAR) begin
         foreach (filt[i]) filt[i] = 1'b0;
         bits_set = '0;
         key_len = 0;
         too_long = 1'b0;
         has = 1'b1;
         r = '{1'b1, 1'b0, 17'd0};
         return;
      end
      n = last ? ((nbytes > 4) ? 4 : nbytes) : 4;
      if (key_len == 0 && !too_long)
         for (int i = 0; i < bfic_pkg::MaxHashes; i++)
            hstate[i] = cfg_seed + bfic_pkg::SEED_TABLE[i];
      if (!too_long) begin
         if (key_len + n > bfic_pkg::MaxKeyBytes) begin
            too_long = 1'b1;
         end else if (n == 4) begin
            k = scramble(word);
            for (int i = 0; i < bfic_pkg::MaxHashes; i++)
               hstate[i] = rotl(hstate[i] ^ k, 13) * 32'd5 + bfic_pkg::MIX_ADD;
            key_len += n;
         end else if (n > 0) begin
            k = scramble(word & ((32'd1 << (8 * n)) - 32'd1));
            for (int i = 0; i < bfic_pkg::MaxHashes; i++) hstate[i] ^= k;
            key_len += n;
         end
      end
      if (!last) return;
      has = 1'b1;
      r.accepted = !too_long && key_len > 0;
      r.present = r.accepted;
      if (r.accepted) begin
         nb = (cfg_bits < 64) ? 64 : ((cfg_bits > bfic_pkg::MaxBits) ? bfic_pkg::MaxBits
                                                                      : cfg_bits);
         nh = (cfg_hashes > bfic_pkg::MaxHashes) ? bfic_pkg::MaxHashes : cfg_hashes;
         for (int i = 0; i < nh; i++) begin
            pos = 16'(fmix(hstate[i], key_len) % nb);
            if (!filt[pos]) begin
               if (mode == bfic_pkg::MODE_INSERT) begin
                  filt[pos] = 1'b1;
                  bits_set++;
               end else begin
                  r.present = 1'b0;
               end
            end
         end
      end
      key_len = 0;
      too_long = 1'b0;
      r.set_count = bits_set;
   endtask

   // Offers one beat; valid stays high from the previous beat unless a gap is taken.
   task automatic send_beat(input logic [1:0] mode, input logic [31:0] word,
                            input logic [2:0] nbytes, input logic last,
                            input bit typed, input lookup_type typed_res);
      int gap;
      bit has;
      lookup_type r;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_key_word <= word;
      req_word_bytes <= nbytes;
      req_last <= last;
      do @(posedge clock); while (!req_ready);
      filter_step(mode, word, nbytes, last, has, r);
      if (has) lookup_q.push_back(typed ? typed_res : r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (lookup_q.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bfic_pkg::CSR_NUM_BITS:   cfg_bits = data[16:0];
         bfic_pkg::CSR_NUM_HASHES: cfg_hashes = data[4:0];
         bfic_pkg::CSR_SEED:       cfg_seed = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("bloom_filter_insert_check_tb: errors");
         $finish;
      end
   end

   // Result checker: each beat is matched against the oldest expectation.
   always @(posedge clock) begin
      lookup_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lookup_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result beat: acc %0b pres %0b cnt %0d",
                        rsp_accepted, rsp_present, rsp_set_count);
         end else begin
            want = lookup_q.pop_front();
            if (want !== {rsp_accepted, rsp_present, rsp_set_count}) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected acc %0b pres %0b cnt %0d, got %0b %0b %0d",
                           want.accepted, want.present, want.set_count,
                           rsp_accepted, rsp_present, rsp_set_count);
            end
         end
      end
   end

   // Receiver back-pressure; a long hold is counted out here when requested.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(0, 17);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      row_type     rows [$];
      logic [31:0] pool [8];
      logic [31:0] word;
      logic [1:0]  mode;
      int          count;
      int          nwords;
      int          phase;

      foreach (filt[i]) filt[i] = 1'b0;
      foreach (hstate[i]) hstate[i] = '0;
      key_len = 0;
      too_long = 1'b0;
      bits_set = '0;
      cfg_bits = 17'd65536;
      cfg_hashes = 5'd7;
      cfg_seed = '0;
      foreach (pool[i]) pool[i] = $urandom;

      rows.push_back('{bfic_pkg::MODE_CLEAR, 32'h0, 3'd0, 1'b1, 1, 1'b1,
                       '{1'b1, 1'b0, 17'd0}});
      rows.push_back('{bfic_pkg::MODE_INSERT, 32'hffffffff, 3'd0, 1'b1, 1, 1'b1,
                       '{1'b0, 1'b0, 17'd0}});
      rows.push_back('{bfic_pkg::MODE_CHECK, 32'h0, 3'd0, 1'b1, 1, 1'b1,
                       '{1'b0, 1'b0, 17'd0}});
      rows.push_back('{bfic_pkg::MODE_UNUSED, 32'hffffffff, 3'd7, 1'b1, 1, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_CHECK, 32'hffffffff, 3'd4, 1'b1, 1, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_INSERT, 32'hffffffff, 3'd4, 1'b1, 1, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_CHECK, 32'hffffffff, 3'd4, 1'b1, 1, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_INSERT, 32'h00000000, 3'd1, 1'b1, 1, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_INSERT, 32'h12345678, 3'd7, 1'b1, 1, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_CHECK, 32'h12345678, 3'd4, 1'b1, 1, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_CHECK, 32'haabbccdd, 3'd2, 1'b0, 1, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_UNUSED, 32'h0, 3'd0, 1'b0, 1, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_INSERT, 32'h00ee0055, 3'd3, 1'b1, 1, 1'b0, '0});
      // A key of exactly the length limit is still taken.
      rows.push_back('{bfic_pkg::MODE_INSERT, 32'ha5a5a5a5, 3'd4, 1'b0, 1023, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_CHECK, 32'h5a5a5a5a, 3'd4, 1'b1, 1, 1'b0, '0});
      // One byte past the limit rejects the key.
      rows.push_back('{bfic_pkg::MODE_INSERT, 32'h3c3c3c3c, 3'd4, 1'b0, 1024, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_INSERT, 32'hc3c3c3c3, 3'd1, 1'b1, 1, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_CLEAR, 32'hffffffff, 3'd7, 1'b0, 1, 1'b1,
                       '{1'b1, 1'b0, 17'd0}});
      rows.push_back('{bfic_pkg::MODE_CHECK, 32'h0, 3'd4, 1'b0, 1025, 1'b0, '0});
      rows.push_back('{bfic_pkg::MODE_CHECK, 32'h1, 3'd4, 1'b1, 1, 1'b1,
                       '{1'b0, 1'b0, 17'd0}});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         repeat (rows[i].reps)
            send_beat(rows[i].mode, rows[i].word, rows[i].nbytes, rows[i].last,
                      rows[i].typed, rows[i].res);
      wait_idle();

      count = 0;
      phase = 0;
      while (count < RandItems) begin
         if (count >= phase * 92) begin
            wait_idle();
            case (phase)
               0: begin
                  csr_write(bfic_pkg::CSR_NUM_BITS, 32'd64);
                  csr_write(bfic_pkg::CSR_NUM_HASHES, 32'd16);
                  csr_write(bfic_pkg::CSR_SEED, 32'hffffffff);
               end
               1: begin
                  csr_write(bfic_pkg::CSR_NUM_BITS, 32'd65536);
                  csr_write(bfic_pkg::CSR_NUM_HASHES, 32'd1);
                  csr_write(bfic_pkg::CSR_SEED, 32'd0);
               end
               2: begin
                  csr_write(bfic_pkg::CSR_NUM_BITS, $urandom);
                  csr_write(bfic_pkg::CSR_NUM_HASHES, 32'd0);
               end
               3: begin
                  csr_write(bfic_pkg::CSR_NUM_BITS, 32'd0);
                  csr_write(bfic_pkg::CSR_NUM_HASHES, 32'hffffffff);
                  csr_write(bfic_pkg::CSR_SEED, $urandom);
               end
               4: begin
                  csr_write(bfic_pkg::CSR_NUM_BITS, 32'(64 * $urandom_range(1, 1024)));
                  csr_write(bfic_pkg::CSR_NUM_HASHES, 32'($urandom_range(1, 16)));
               end
               default: begin
                  csr_write(bfic_pkg::CSR_NUM_BITS, 32'h1ffff);
                  csr_write(bfic_pkg::CSR_NUM_HASHES, 32'($urandom_range(2, 9)));
                  csr_write(bfic_pkg::CSR_SEED, $urandom);
               end
            endcase
            phase++;
         end
         if (count == 150) long_hold = 1'b1;
         if (count == 300) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (lookup_q.size() != 0) @(posedge clock);
         end
         quiet = (count >= RandItems - QuietItems);
         case ($urandom_range(0, 99)) inside
            [0:6]: send_beat(bfic_pkg::MODE_UNUSED, $urandom, 3'($urandom), 1'($urandom),
                             1'b0, '0);
            [7:7]: begin
               send_beat(bfic_pkg::MODE_CLEAR, $urandom, 3'($urandom), 1'($urandom),
                         1'b0, '0);
               count++;
            end
            [8:14]: begin
               // Broken key: a clear lands in the middle of it.
               send_beat(2'($urandom_range(0, 1)), $urandom, 3'($urandom), 1'b0, 1'b0, '0);
               send_beat(bfic_pkg::MODE_CLEAR, $urandom, 3'($urandom), 1'($urandom),
                         1'b0, '0);
               count += 2;
            end
            default: begin
               nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12)
                                                   : $urandom_range(1, 3);
               mode = ($urandom_range(0, 1) == 0) ? bfic_pkg::MODE_INSERT
                                                  : bfic_pkg::MODE_CHECK;
               for (int w = 0; w < nwords; w++) begin
                  word = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 7)]
                                                     : $urandom;
                  if (w == nwords - 1)
                     send_beat(mode, word,
                               ($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'd4,
                               1'b1, 1'b0, '0);
                  else
                     send_beat(2'($urandom_range(0, 1)), word, 3'($urandom), 1'b0,
                               1'b0, '0);
                  count++;
               end
            end
         endcase
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (lookup_q.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (errors == 0 && lookup_q.size() == 0) begin
         $display("bloom_filter_insert_check_tb: clean");
      end else begin
         $display("bloom_filter_insert_check_tb: errors");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/bfic_pkg.sv
rtl/core/bloom_filter_insert_check.sv
dv/bloom_filter_insert_check_tb.sv
